FILE: rtl/core/pwi_pkg.sv
`default_nettype none
package pwi_pkg;

    localparam int VEL_W      = 32;
    localparam int NRM_W      = 18;
    localparam int COEF_W     = 16;
    localparam int CNT_W      = 32;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_LANES  = 3;

    localparam int NRM_FRAC  = 16;
    localparam int COEF_FRAC = 15;

    // datapath widths, sized for the worst case of the input ranges
    localparam int U_W   = VEL_W + 1;
    localparam int PD_W  = U_W + NRM_W;
    localparam int DOT_W = PD_W + 2;
    localparam int UN_W  = 37;
    localparam int EC_W  = COEF_W + 2;
    localparam int SCP_W = EC_W + UN_W;
    localparam int SC_W  = 40;
    localparam int PN_W  = UN_W + NRM_W;
    localparam int TD_W  = PN_W + 1;
    localparam int UT_W  = 40;
    localparam int RN_W  = SC_W + NRM_W;
    localparam int R_W   = 42;
    localparam int FC_W  = COEF_W + 1;
    localparam int FP_W  = FC_W + UT_W;
    localparam int SUM_W = R_W + 2;

    localparam logic [MODE_W-1:0] MODE_ESCAPE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REBOUND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET        = MODE_REBOUND;
    localparam logic [COEF_W-1:0] ONE_Q15           = 16'd32768;
    localparam logic [COEF_W-1:0] RESTITUTION_RESET = ONE_Q15;
    localparam logic [COEF_W-1:0] FRICTION_RESET    = 16'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_TANG,
        ST_FRIC,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_ZERO,
        KIND_REBOUND
    } t_kind;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic scale;
        logic tang;
        logic fric;
    } t_lane_ctl;

endpackage
`default_nettype wire

FILE: rtl/core/pwi_in_if.sv
`default_nettype none
interface pwi_in_if;
    logic                                valid;
    logic                                ready;
    logic                                is_wall;
    logic                                active_in;
    logic signed [pwi_pkg::VEL_W-1:0]    vel_x;
    logic signed [pwi_pkg::VEL_W-1:0]    vel_y;
    logic signed [pwi_pkg::VEL_W-1:0]    vel_z;
    logic signed [pwi_pkg::VEL_W-1:0]    wall_vel_x;
    logic signed [pwi_pkg::VEL_W-1:0]    wall_vel_y;
    logic signed [pwi_pkg::VEL_W-1:0]    wall_vel_z;
    logic signed [pwi_pkg::NRM_W-1:0]    normal_x;
    logic signed [pwi_pkg::NRM_W-1:0]    normal_y;
    logic signed [pwi_pkg::NRM_W-1:0]    normal_z;

    modport source (
        output valid, is_wall, active_in, vel_x, vel_y, vel_z,
               wall_vel_x, wall_vel_y, wall_vel_z, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, is_wall, active_in, vel_x, vel_y, vel_z,
               wall_vel_x, wall_vel_y, wall_vel_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/pwi_out_if.sv
`default_nettype none
interface pwi_out_if;
    logic                                valid;
    logic                                ready;
    logic                                handled;
    logic                                keep;
    logic                                active_out;
    logic signed [pwi_pkg::VEL_W-1:0]    new_vel_x;
    logic signed [pwi_pkg::VEL_W-1:0]    new_vel_y;
    logic signed [pwi_pkg::VEL_W-1:0]    new_vel_z;
    logic        [pwi_pkg::CNT_W-1:0]    escaped_total;
    logic        [pwi_pkg::CNT_W-1:0]    stuck_total;

    modport source (
        output valid, handled, keep, active_out, new_vel_x, new_vel_y, new_vel_z,
               escaped_total, stuck_total,
        input  ready
    );
    modport sink (
        input  valid, handled, keep, active_out, new_vel_x, new_vel_y, new_vel_z,
               escaped_total, stuck_total,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/pwi_cfg_if.sv
`default_nettype none
interface pwi_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pwi_pkg::CFG_IDX_W-1:0]       index;
    logic [pwi_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pwi_lane.sv
`default_nettype none
module pwi_lane (
    input  logic                                i_clk,
    input  pwi_pkg::t_lane_ctl                  i_ctl,
    input  logic signed [pwi_pkg::VEL_W-1:0]    i_vel,
    input  logic signed [pwi_pkg::VEL_W-1:0]    i_wall_vel,
    input  logic signed [pwi_pkg::NRM_W-1:0]    i_normal,
    input  logic signed [pwi_pkg::UN_W-1:0]     i_un,
    input  logic signed [pwi_pkg::SC_W-1:0]     i_sc,
    input  logic        [pwi_pkg::COEF_W-1:0]   i_friction,
    output logic signed [pwi_pkg::PD_W-1:0]     o_pd,
    output logic signed [pwi_pkg::VEL_W-1:0]    o_vel,
    output logic signed [pwi_pkg::VEL_W-1:0]    o_new_vel
);

    localparam int VEL_W  = pwi_pkg::VEL_W;
    localparam int NRM_W  = pwi_pkg::NRM_W;
    localparam int U_W    = pwi_pkg::U_W;
    localparam int PD_W   = pwi_pkg::PD_W;
    localparam int PN_W   = pwi_pkg::PN_W;
    localparam int TD_W   = pwi_pkg::TD_W;
    localparam int UT_W   = pwi_pkg::UT_W;
    localparam int RN_W   = pwi_pkg::RN_W;
    localparam int R_W    = pwi_pkg::R_W;
    localparam int FC_W   = pwi_pkg::FC_W;
    localparam int FP_W   = pwi_pkg::FP_W;
    localparam int SUM_W  = pwi_pkg::SUM_W;
    localparam int NFRAC  = pwi_pkg::NRM_FRAC;
    localparam int CFRAC  = pwi_pkg::COEF_FRAC;

    logic signed [VEL_W-1:0] r_v;
    logic signed [U_W-1:0]   r_u;
    logic signed [NRM_W-1:0] r_n;
    logic signed [PD_W-1:0]  r_pd;
    logic signed [PN_W-1:0]  r_pn;
    logic signed [UT_W-1:0]  r_ut;
    logic signed [RN_W-1:0]  r_rn;
    logic signed [FP_W-1:0]  r_fp;
    logic signed [R_W-1:0]   r_r;

    logic signed [FC_W-1:0]  fr_s;
    logic signed [PD_W-1:0]  pd_c;
    logic signed [PN_W-1:0]  pn_c;
    logic signed [TD_W-1:0]  td_c;
    logic signed [UT_W-1:0]  ut_c;
    logic signed [RN_W-1:0]  rn_c;
    logic signed [RN_W-1:0]  rr_c;
    logic signed [R_W-1:0]   r_c;
    logic signed [FP_W-1:0]  fp_c;
    logic signed [FP_W-1:0]  fr_c;
    logic signed [R_W-1:0]   f_c;
    logic signed [SUM_W-1:0] sum_c;
    logic [SUM_W-VEL_W:0]    sum_hi;

    always_comb begin
        fr_s = signed'({1'b0, i_friction});
        pd_c = PD_W'(r_u) * PD_W'(r_n);
        pn_c = PN_W'(i_un) * PN_W'(r_n);
        // tangential part, rounded half up from Q.32
        td_c = (TD_W'(r_u) <<< NFRAC) - TD_W'(r_pn) + (TD_W'(1) <<< (NFRAC - 1));
        ut_c = UT_W'(td_c >>> NFRAC);
        rn_c = RN_W'(i_sc) * RN_W'(r_n);
        rr_c = r_rn + (RN_W'(1) <<< (NFRAC - 1));
        r_c  = R_W'(rr_c >>> NFRAC);
        fp_c = FP_W'(fr_s) * FP_W'(r_ut);
        fr_c = r_fp + (FP_W'(1) <<< (CFRAC - 1));
        f_c  = R_W'(fr_c >>> CFRAC);
        sum_c  = SUM_W'(r_v) - SUM_W'(r_r) - SUM_W'(f_c);
        sum_hi = sum_c[SUM_W-1:VEL_W-1];
        if ((&sum_hi) || !(|sum_hi)) begin
            o_new_vel = sum_c[VEL_W-1:0];
        end else if (sum_c[SUM_W-1]) begin
            o_new_vel = {1'b1, {(VEL_W-1){1'b0}}};
        end else begin
            o_new_vel = {1'b0, {(VEL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_vel;
            r_u <= U_W'(i_vel) - U_W'(i_wall_vel);
            r_n <= i_normal;
        end
        if (i_ctl.mul) begin
            r_pd <= pd_c;
        end
        if (i_ctl.scale) begin
            r_pn <= pn_c;
        end
        if (i_ctl.tang) begin
            r_ut <= ut_c;
            r_rn <= rn_c;
        end
        if (i_ctl.fric) begin
            r_fp <= fp_c;
            r_r  <= r_c;
        end
    end

    assign o_pd  = r_pd;
    assign o_vel = r_v;

endmodule
`default_nettype wire

FILE: rtl/core/pwi_merge.sv
`default_nettype none
module pwi_merge (
    input  logic                                i_clk,
    input  pwi_pkg::t_lane_ctl                  i_ctl,
    input  logic signed [pwi_pkg::PD_W-1:0]     i_pd [pwi_pkg::NUM_LANES],
    input  logic        [pwi_pkg::COEF_W-1:0]   i_restitution,
    output logic signed [pwi_pkg::UN_W-1:0]     o_un,
    output logic signed [pwi_pkg::SC_W-1:0]     o_sc
);

    localparam int DOT_W = pwi_pkg::DOT_W;
    localparam int UN_W  = pwi_pkg::UN_W;
    localparam int EC_W  = pwi_pkg::EC_W;
    localparam int SCP_W = pwi_pkg::SCP_W;
    localparam int SC_W  = pwi_pkg::SC_W;
    localparam int NFRAC = pwi_pkg::NRM_FRAC;
    localparam int CFRAC = pwi_pkg::COEF_FRAC;

    logic signed [UN_W-1:0]  r_un;
    logic signed [SC_W-1:0]  r_sc;

    logic signed [DOT_W-1:0] dot_c;
    logic signed [UN_W-1:0]  un_c;
    logic signed [EC_W-1:0]  ec_c;
    logic signed [SCP_W-1:0] scp_c;
    logic signed [SC_W-1:0]  sc_c;

    always_comb begin
        dot_c = DOT_W'(1) <<< (NFRAC - 1);
        for (int k = 0; k < pwi_pkg::NUM_LANES; k++) begin
            dot_c = dot_c + DOT_W'(i_pd[k]);
        end
        un_c  = UN_W'(dot_c >>> NFRAC);
        // scale is 1 + e
        ec_c  = signed'({2'b00, i_restitution}) + signed'({2'b00, pwi_pkg::ONE_Q15});
        scp_c = SCP_W'(ec_c) * SCP_W'(r_un) + (SCP_W'(1) <<< (CFRAC - 1));
        // only a normal component moving into the wall is reflected
        if (!r_un[UN_W-1] && (|r_un)) begin
            sc_c = SC_W'(scp_c >>> CFRAC);
        end else begin
            sc_c = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            r_un <= un_c;
        end
        if (i_ctl.scale) begin
            r_sc <= sc_c;
        end
    end

    assign o_un = r_un;
    assign o_sc = r_sc;

endmodule
`default_nettype wire

FILE: rtl/core/particle_wall_interaction_core.sv
`default_nettype none
// Particle wall interaction: one particle-meets-patch event per input transaction, one
// result transaction per event. Events are processed one at a time. A rebound event runs
// from the accepting edge through the MUL, SUM, SCALE, TANG and FRIC states to DONE, and
// the input is ready again from the edge that registers the result; every other event
// goes straight from acceptance to DONE. The rebound path runs through the
// chain of three velocity lanes and the merge unit: u.n products, the summed
// normal component, the (1 + e) scaling and projection, the tangential part and the
// friction product, each followed by a register. A result waiting in the output register
// does not block acceptance; only a second finished result waits for it to drain.
// Configuration writes are always ready and take effect at once; the escape and stick
// counters saturate at all ones and clear only on reset.
module particle_wall_interaction_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pwi_in_if.sink       i_in,
    pwi_cfg_if.sink      i_cfg,
    pwi_out_if.source    o_out
);

    localparam int NL     = pwi_pkg::NUM_LANES;
    localparam int VEL_W  = pwi_pkg::VEL_W;
    localparam int NRM_W  = pwi_pkg::NRM_W;
    localparam int COEF_W = pwi_pkg::COEF_W;
    localparam int CNT_W  = pwi_pkg::CNT_W;
    localparam int MODE_W = pwi_pkg::MODE_W;

    logic [MODE_W-1:0]    r_mode;
    logic [COEF_W-1:0]    r_restitution;
    logic [COEF_W-1:0]    r_friction;
    pwi_pkg::t_state      r_state, n_state;
    pwi_pkg::t_kind       r_kind;
    logic                 r_handled, r_keep, r_active;
    logic [CNT_W-1:0]     r_escape_count, r_stuck_count;

    logic                 r_out_valid;
    logic                 r_out_handled, r_out_keep, r_out_active;
    logic signed [VEL_W-1:0] r_out_vel [NL];
    logic [CNT_W-1:0]     r_out_escaped, r_out_stuck;

    pwi_pkg::t_lane_ctl   lane_ctl;
    logic                 in_acc;
    logic                 out_load;
    logic                 wall_escape, wall_stick, wall_rebound;

    logic signed [VEL_W-1:0]        vel_in   [NL];
    logic signed [VEL_W-1:0]        wvel_in  [NL];
    logic signed [NRM_W-1:0]        nrm_in   [NL];
    logic signed [pwi_pkg::PD_W-1:0] pd      [NL];
    logic signed [VEL_W-1:0]        lane_vel [NL];
    logic signed [VEL_W-1:0]        lane_new [NL];
    logic signed [pwi_pkg::UN_W-1:0] un;
    logic signed [pwi_pkg::SC_W-1:0] sc;

    assign vel_in[0]  = i_in.vel_x;
    assign vel_in[1]  = i_in.vel_y;
    assign vel_in[2]  = i_in.vel_z;
    assign wvel_in[0] = i_in.wall_vel_x;
    assign wvel_in[1] = i_in.wall_vel_y;
    assign wvel_in[2] = i_in.wall_vel_z;
    assign nrm_in[0]  = i_in.normal_x;
    assign nrm_in[1]  = i_in.normal_y;
    assign nrm_in[2]  = i_in.normal_z;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == pwi_pkg::ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;

    assign wall_escape  = i_in.is_wall && (r_mode == pwi_pkg::MODE_ESCAPE);
    assign wall_stick   = i_in.is_wall && (r_mode == pwi_pkg::MODE_STICK);
    assign wall_rebound = i_in.is_wall && (r_mode == pwi_pkg::MODE_REBOUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= pwi_pkg::MODE_RESET;
            r_restitution <= pwi_pkg::RESTITUTION_RESET;
            r_friction    <= pwi_pkg::FRICTION_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pwi_pkg::REG_MODE:        r_mode        <= i_cfg.data[MODE_W-1:0];
                pwi_pkg::REG_RESTITUTION: r_restitution <= i_cfg.data[COEF_W-1:0];
                pwi_pkg::REG_FRICTION:    r_friction    <= i_cfg.data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // event classification and counters at acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_count <= '0;
            r_stuck_count  <= '0;
        end else if (in_acc) begin
            if (wall_escape && (r_escape_count != '1)) begin
                r_escape_count <= r_escape_count + CNT_W'(1);
            end
            if (wall_stick && (r_stuck_count != '1)) begin
                r_stuck_count <= r_stuck_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            priority if (wall_escape) begin
                r_kind    <= pwi_pkg::KIND_ZERO;
                r_handled <= 1'b1;
                r_keep    <= 1'b0;
                r_active  <= 1'b0;
            end else if (wall_stick) begin
                r_kind    <= pwi_pkg::KIND_ZERO;
                r_handled <= 1'b1;
                r_keep    <= 1'b1;
                r_active  <= 1'b0;
            end else if (wall_rebound) begin
                r_kind    <= pwi_pkg::KIND_REBOUND;
                r_handled <= 1'b1;
                r_keep    <= 1'b1;
                r_active  <= 1'b1;
            end else begin
                r_kind    <= pwi_pkg::KIND_PASS;
                r_handled <= 1'b0;
                r_keep    <= 1'b1;
                r_active  <= i_in.active_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        lane_ctl = '0;
        out_load = 1'b0;
        lane_ctl.load = in_acc;
        unique case (r_state)
            pwi_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = wall_rebound ? pwi_pkg::ST_MUL : pwi_pkg::ST_DONE;
                end
            end
            pwi_pkg::ST_MUL: begin
                lane_ctl.mul = 1'b1;
                n_state      = pwi_pkg::ST_SUM;
            end
            pwi_pkg::ST_SUM: begin
                lane_ctl.sum = 1'b1;
                n_state      = pwi_pkg::ST_SCALE;
            end
            pwi_pkg::ST_SCALE: begin
                lane_ctl.scale = 1'b1;
                n_state        = pwi_pkg::ST_TANG;
            end
            pwi_pkg::ST_TANG: begin
                lane_ctl.tang = 1'b1;
                n_state       = pwi_pkg::ST_FRIC;
            end
            pwi_pkg::ST_FRIC: begin
                lane_ctl.fric = 1'b1;
                n_state       = pwi_pkg::ST_DONE;
            end
            pwi_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = pwi_pkg::ST_IDLE;
                end
            end
            default: n_state = pwi_pkg::ST_IDLE;
        endcase
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        pwi_lane u_lane (
            .i_clk      (i_clk),
            .i_ctl      (lane_ctl),
            .i_vel      (vel_in[g]),
            .i_wall_vel (wvel_in[g]),
            .i_normal   (nrm_in[g]),
            .i_un       (un),
            .i_sc       (sc),
            .i_friction (r_friction),
            .o_pd       (pd[g]),
            .o_vel      (lane_vel[g]),
            .o_new_vel  (lane_new[g])
        );
    end

    pwi_merge u_merge (
        .i_clk         (i_clk),
        .i_ctl         (lane_ctl),
        .i_pd          (pd),
        .i_restitution (r_restitution),
        .o_un          (un),
        .o_sc          (sc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_handled <= r_handled;
            r_out_keep    <= r_keep;
            r_out_active  <= r_active;
            r_out_escaped <= r_escape_count;
            r_out_stuck   <= r_stuck_count;
            for (int k = 0; k < NL; k++) begin
                unique case (r_kind)
                    pwi_pkg::KIND_ZERO:    r_out_vel[k] <= '0;
                    pwi_pkg::KIND_REBOUND: r_out_vel[k] <= lane_new[k];
                    default:               r_out_vel[k] <= lane_vel[k];
                endcase
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.handled       = r_out_handled;
    assign o_out.keep          = r_out_keep;
    assign o_out.active_out    = r_out_active;
    assign o_out.new_vel_x     = r_out_vel[0];
    assign o_out.new_vel_y     = r_out_vel[1];
    assign o_out.new_vel_z     = r_out_vel[2];
    assign o_out.escaped_total = r_out_escaped;
    assign o_out.stuck_total   = r_out_stuck;

endmodule
`default_nettype wire

FILE: rtl/core/pwi_checker.sv
`default_nettype none
module pwi_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    input  wire                            i_in_ready,
    input  wire                            i_out_valid,
    input  wire                            i_out_ready,
    input  wire                            i_handled,
    input  wire                            i_keep,
    input  wire                            i_active_out,
    input  wire [pwi_pkg::VEL_W-1:0]       i_new_vel_x,
    input  wire [pwi_pkg::VEL_W-1:0]       i_new_vel_y,
    input  wire [pwi_pkg::VEL_W-1:0]       i_new_vel_z,
    input  wire [pwi_pkg::CNT_W-1:0]       i_escaped_total,
    input  wire [pwi_pkg::CNT_W-1:0]       i_stuck_total
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_handled, i_keep, i_active_out, i_new_vel_x, i_new_vel_y,
                     i_new_vel_z, i_escaped_total, i_stuck_total}))
        else $error("result changed while stalled");

    // one event in flight: no back-to-back acceptance
    a_single_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while an event is in progress");

    // a removed particle is always a handled, inactive one
    a_remove_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_keep |-> i_handled && !i_active_out)
        else $error("particle removed without a handled escape");

    // counters never go backwards between shown results
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && $past(i_out_valid) && $past(i_rst_n) |->
            (i_escaped_total >= $past(i_escaped_total)) &&
            (i_stuck_total >= $past(i_stuck_total)))
        else $error("event counter decreased");

endmodule

bind particle_wall_interaction_core pwi_checker u_pwi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_handled       (o_out.handled),
    .i_keep          (o_out.keep),
    .i_active_out    (o_out.active_out),
    .i_new_vel_x     (o_out.new_vel_x),
    .i_new_vel_y     (o_out.new_vel_y),
    .i_new_vel_z     (o_out.new_vel_z),
    .i_escaped_total (o_out.escaped_total),
    .i_stuck_total   (o_out.stuck_total)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
module testbench;
    import pwi_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int Q_ONE           = 65536;
    localparam int VEL_MAX         = 32'sh7fff_ffff;
    localparam int VEL_MIN         = 32'sh8000_0000;
    localparam int NRM_MAX         = 131071;
    localparam int NRM_MIN         = -131072;
    localparam int NUM_SEGMENTS    = 9;
    localparam int SEGMENT_EVENTS  = 95;
    localparam int STALL_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 20;
    localparam int MAX_PRINTS      = 100;

    typedef struct packed {
        logic                    is_wall;
        logic                    active_in;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
        logic signed [VEL_W-1:0] wall_vel_x;
        logic signed [VEL_W-1:0] wall_vel_y;
        logic signed [VEL_W-1:0] wall_vel_z;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
    } wall_event_t;

    typedef struct packed {
        logic                    handled;
        logic                    keep;
        logic                    active_out;
        logic signed [VEL_W-1:0] new_vel_x;
        logic signed [VEL_W-1:0] new_vel_y;
        logic signed [VEL_W-1:0] new_vel_z;
        logic [CNT_W-1:0]        escaped_total;
        logic [CNT_W-1:0]        stuck_total;
    } wall_result_t;

    class rebound_scoreboard;
        logic [MODE_W-1:0] mode;
        logic [COEF_W-1:0] restitution;
        logic [COEF_W-1:0] friction;
        logic [CNT_W-1:0]  escape_count;
        logic [CNT_W-1:0]  stick_count;
        wall_result_t      expected_results[$];
        int                mismatches;
        int                results_seen;

        function new();
            mode         = MODE_RESET;
            restitution  = RESTITUTION_RESET;
            friction     = FRICTION_RESET;
            escape_count = '0;
            stick_count  = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:        mode = data[MODE_W-1:0];
                REG_RESTITUTION: restitution = data[COEF_W-1:0];
                REG_FRICTION:    friction = data[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        // round half up: floor(x / 2^k + 1/2)
        function longint round_shift(longint x, int k);
            return (x + (64'sd1 <<< (k - 1))) >>> k;
        endfunction

        function logic [VEL_W-1:0] sat_vel(longint x);
            if (x > 64'sd2147483647) return 32'h7fff_ffff;
            if (x < -64'sd2147483648) return 32'h8000_0000;
            return x[VEL_W-1:0];
        endfunction

        function wall_result_t predict_wall_result(wall_event_t ev);
            wall_result_t res;
            longint v [3];
            longint w [3];
            longint n [3];
            longint u [3];
            logic [VEL_W-1:0] nv [3];
            longint dot, un, sc, ut, r, f, e_q, mu_q;
            v[0] = $signed(ev.vel_x);
            v[1] = $signed(ev.vel_y);
            v[2] = $signed(ev.vel_z);
            w[0] = $signed(ev.wall_vel_x);
            w[1] = $signed(ev.wall_vel_y);
            w[2] = $signed(ev.wall_vel_z);
            n[0] = $signed(ev.normal_x);
            n[1] = $signed(ev.normal_y);
            n[2] = $signed(ev.normal_z);
            for (int i = 0; i < NUM_LANES; i++) nv[i] = v[i][VEL_W-1:0];
            res.handled    = 1'b0;
            res.keep       = 1'b1;
            res.active_out = ev.active_in;
            if (ev.is_wall && mode == MODE_ESCAPE) begin
                res.handled    = 1'b1;
                res.keep       = 1'b0;
                res.active_out = 1'b0;
                for (int i = 0; i < NUM_LANES; i++) nv[i] = '0;
                if (escape_count != '1) escape_count++;
            end else if (ev.is_wall && mode == MODE_STICK) begin
                res.handled    = 1'b1;
                res.active_out = 1'b0;
                for (int i = 0; i < NUM_LANES; i++) nv[i] = '0;
                if (stick_count != '1) stick_count++;
            end else if (ev.is_wall && mode == MODE_REBOUND) begin
                res.handled    = 1'b1;
                res.active_out = 1'b1;
                e_q  = restitution;
                mu_q = friction;
                dot  = 0;
                for (int i = 0; i < NUM_LANES; i++) begin
                    u[i] = v[i] - w[i];
                    dot += u[i] * n[i];
                end
                un = round_shift(dot, NRM_FRAC);
                sc = 0;
                if (un > 0) sc = round_shift((e_q + ONE_Q15) * un, COEF_FRAC);
                for (int i = 0; i < NUM_LANES; i++) begin
                    ut = round_shift(u[i] * Q_ONE - un * n[i], NRM_FRAC);
                    r  = (un > 0) ? round_shift(sc * n[i], NRM_FRAC) : 0;
                    f  = round_shift(mu_q * ut, COEF_FRAC);
                    nv[i] = sat_vel(v[i] - r - f);
                end
            end
            res.new_vel_x     = nv[0];
            res.new_vel_y     = nv[1];
            res.new_vel_z     = nv[2];
            res.escaped_total = escape_count;
            res.stuck_total   = stick_count;
            return res;
        endfunction

        function void note_event(wall_event_t ev);
            expected_results.push_back(predict_wall_result(ev));
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTS) $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %h expected %h",
                                          results_seen, name, got, want));
        endtask

        task check_result(wall_result_t got);
            wall_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end else begin
                want = expected_results.pop_front();
                compare_field("handled", got.handled, want.handled);
                compare_field("keep", got.keep, want.keep);
                compare_field("active_out", got.active_out, want.active_out);
                compare_field("new_vel_x", got.new_vel_x, want.new_vel_x);
                compare_field("new_vel_y", got.new_vel_y, want.new_vel_y);
                compare_field("new_vel_z", got.new_vel_z, want.new_vel_z);
                compare_field("escaped_total", got.escaped_total, want.escaped_total);
                compare_field("stuck_total", got.stuck_total, want.stuck_total);
            end
            results_seen++;
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   tx_idle_pct = 15;
    int   rx_idle_pct = 61;
    int   idle_cycles = 0;

    pwi_in_if  in_if();
    pwi_cfg_if cfg_if();
    pwi_out_if out_if();

    rebound_scoreboard sb = new();

    particle_wall_interaction_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        in_if.valid      = 1'b0;
        in_if.is_wall    = 1'b0;
        in_if.active_in  = 1'b0;
        in_if.vel_x      = '0;
        in_if.vel_y      = '0;
        in_if.vel_z      = '0;
        in_if.wall_vel_x = '0;
        in_if.wall_vel_y = '0;
        in_if.wall_vel_z = '0;
        in_if.normal_x   = '0;
        in_if.normal_y   = '0;
        in_if.normal_z   = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_MODE;
        cfg_if.data      = '0;
        out_if.ready     = 1'b0;
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // transaction monitor: feeds the scoreboard and the stall counter
    always @(posedge i_clk) begin
        wall_event_t  ev;
        wall_result_t res;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                res.handled       = out_if.handled;
                res.keep          = out_if.keep;
                res.active_out    = out_if.active_out;
                res.new_vel_x     = out_if.new_vel_x;
                res.new_vel_y     = out_if.new_vel_y;
                res.new_vel_z     = out_if.new_vel_z;
                res.escaped_total = out_if.escaped_total;
                res.stuck_total   = out_if.stuck_total;
                sb.check_result(res);
            end
            if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready) begin
                ev.is_wall    = in_if.is_wall;
                ev.active_in  = in_if.active_in;
                ev.vel_x      = in_if.vel_x;
                ev.vel_y      = in_if.vel_y;
                ev.vel_z      = in_if.vel_z;
                ev.wall_vel_x = in_if.wall_vel_x;
                ev.wall_vel_y = in_if.wall_vel_y;
                ev.wall_vel_z = in_if.wall_vel_z;
                ev.normal_x   = in_if.normal_x;
                ev.normal_y   = in_if.normal_y;
                ev.normal_z   = in_if.normal_z;
                sb.note_event(ev);
            end
        end
        if ((out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (in_if.valid && in_if.ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("testbench failed");
        $finish;
    end

    task automatic wait_drained();
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
    endtask

    task automatic send_event(wall_event_t ev);
        int gap = 0;
        while (gap < 30 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.is_wall    <= ev.is_wall;
        in_if.active_in  <= ev.active_in;
        in_if.vel_x      <= ev.vel_x;
        in_if.vel_y      <= ev.vel_y;
        in_if.vel_z      <= ev.vel_z;
        in_if.wall_vel_x <= ev.wall_vel_x;
        in_if.wall_vel_y <= ev.wall_vel_y;
        in_if.wall_vel_z <= ev.wall_vel_z;
        in_if.normal_x   <= ev.normal_x;
        in_if.normal_y   <= ev.normal_y;
        in_if.normal_z   <= ev.normal_z;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // stops the event stream, waits for the block to drain, then writes all registers
    task automatic configure(logic [MODE_W-1:0] m, logic [COEF_W-1:0] e,
                             logic [COEF_W-1:0] mu);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = REG_MODE;
        idx[1] = REG_RESTITUTION;
        idx[2] = REG_FRICTION;
        val[0] = {{(CFG_DATA_W-MODE_W){1'b0}}, m};
        val[1] = e;
        val[2] = mu;
        in_if.valid <= 1'b0;
        wait_drained();
        for (int i = 0; i < 3; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= val[i];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic wall_event_t make_event(bit wall, bit act, int vx, int vy, int vz,
                                               int wx, int wy, int wz,
                                               int nx, int ny, int nz);
        wall_event_t ev;
        ev.is_wall    = wall;
        ev.active_in  = act;
        ev.vel_x      = vx;
        ev.vel_y      = vy;
        ev.vel_z      = vz;
        ev.wall_vel_x = wx;
        ev.wall_vel_y = wy;
        ev.wall_vel_z = wz;
        ev.normal_x   = nx;
        ev.normal_y   = ny;
        ev.normal_z   = nz;
        return ev;
    endfunction

    function automatic logic signed [VEL_W-1:0] random_velocity();
        case ($urandom_range(9))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(3))
                    0: return VEL_MAX;
                    1: return VEL_MIN;
                    2: return 0;
                    default: return -1;
                endcase
            end
            // within +-64.0, where the rebound stays clear of saturation
            default: return int'($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
        endcase
    endfunction

    function automatic wall_event_t random_event();
        wall_event_t ev;
        int shape;
        int axis;
        ev.is_wall    = ($urandom_range(99) < 85);
        ev.active_in  = $urandom_range(1);
        ev.vel_x      = random_velocity();
        ev.vel_y      = random_velocity();
        ev.vel_z      = random_velocity();
        ev.wall_vel_x = random_velocity();
        ev.wall_vel_y = random_velocity();
        ev.wall_vel_z = random_velocity();
        shape = $urandom_range(99);
        if (shape < 40) begin
            axis = $urandom_range(2);
            ev.normal_x = (axis == 0) ? ($urandom_range(1) ? Q_ONE : -Q_ONE) : 0;
            ev.normal_y = (axis == 1) ? ($urandom_range(1) ? Q_ONE : -Q_ONE) : 0;
            ev.normal_z = (axis == 2) ? ($urandom_range(1) ? Q_ONE : -Q_ONE) : 0;
        end else if (shape < 85) begin
            ev.normal_x = int'($urandom_range(2 * Q_ONE)) - Q_ONE;
            ev.normal_y = int'($urandom_range(2 * Q_ONE)) - Q_ONE;
            ev.normal_z = int'($urandom_range(2 * Q_ONE)) - Q_ONE;
        end else begin
            // any 18-bit pattern, not normalised to unit length
            ev.normal_x = $urandom();
            ev.normal_y = $urandom();
            ev.normal_z = $urandom();
        end
        return ev;
    endfunction

    task automatic set_idling(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic directed_events();
        // reset settings: rebound, e = 1.0, no friction
        send_event(make_event(0, 1, VEL_MAX, VEL_MIN, 0, VEL_MIN, VEL_MAX, 1, Q_ONE, 0, 0));
        send_event(make_event(0, 0, -5 * Q_ONE, 3 * Q_ONE, 7, 0, 0, 0, 0, -Q_ONE, 0));
        send_event(make_event(1, 1, -2 * Q_ONE, 0, 0, 0, 0, 0, -Q_ONE, 0, 0));
        send_event(make_event(1, 0, 2 * Q_ONE, Q_ONE, 0, 0, 0, 0, -Q_ONE, 0, 0));
        send_event(make_event(1, 1, 0, 3 * Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0));
        send_event(make_event(1, 1, Q_ONE, 0, 0, 3 * Q_ONE, -Q_ONE, 2 * Q_ONE, 0, 0, Q_ONE));
        send_event(make_event(1, 1, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MIN, VEL_MIN, VEL_MIN,
                              Q_ONE, Q_ONE, Q_ONE));
        send_event(make_event(1, 1, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MAX, VEL_MAX, VEL_MAX,
                              -Q_ONE, -Q_ONE, -Q_ONE));
        // normal far from unit length at the field extremes
        send_event(make_event(1, 1, 5 * Q_ONE, -3 * Q_ONE, Q_ONE, 0, 0, 0,
                              NRM_MAX, NRM_MIN, NRM_MAX));
        // half-lsb rounding
        send_event(make_event(1, 1, 1, -1, 3, 0, 0, 0, Q_ONE / 2, -Q_ONE / 2, Q_ONE / 2));

        configure(MODE_REBOUND, 16'd0, ONE_Q15);
        send_event(make_event(1, 1, -3 * Q_ONE, 2 * Q_ONE, Q_ONE, 0, 0, 0, -Q_ONE, 0, 0));
        send_event(make_event(1, 1, Q_ONE, -Q_ONE, 0, -Q_ONE, 0, Q_ONE, 46341, 46341, 0));

        // coefficients above 1.0
        configure(MODE_REBOUND, 16'hffff, 16'hffff);
        send_event(make_event(1, 1, -1000 * Q_ONE, 500 * Q_ONE, -77, Q_ONE, Q_ONE, Q_ONE,
                              0, -Q_ONE, 0));
        send_event(make_event(1, 1, VEL_MAX, VEL_MIN, VEL_MAX, VEL_MIN, VEL_MAX, VEL_MIN,
                              0, Q_ONE, 0));

        configure(MODE_ESCAPE, ONE_Q15, 16'd0);
        send_event(make_event(1, 1, 4 * Q_ONE, -Q_ONE, 9, 0, 0, 0, 0, 0, Q_ONE));
        send_event(make_event(0, 1, -4 * Q_ONE, Q_ONE, -9, 0, 0, 0, 0, 0, Q_ONE));
        send_event(make_event(1, 0, VEL_MIN, VEL_MAX, 0, 0, 0, 0, -Q_ONE, 0, 0));

        configure(MODE_STICK, ONE_Q15, 16'd0);
        send_event(make_event(1, 1, 4 * Q_ONE, -Q_ONE, 9, 0, 0, 0, 0, 0, Q_ONE));
        send_event(make_event(1, 0, -Q_ONE, 2 * Q_ONE, 0, Q_ONE, 0, 0, Q_ONE, 0, 0));
        send_event(make_event(0, 0, 11, 22, 33, 0, 0, 0, 0, Q_ONE, 0));

        // unused mode code: wall events pass through
        configure(MODE_UNUSED, ONE_Q15, 16'd0);
        send_event(make_event(1, 1, -2 * Q_ONE, 0, 0, 0, 0, 0, -Q_ONE, 0, 0));
        send_event(make_event(0, 0, VEL_MAX, 0, VEL_MIN, 0, 0, 0, 0, 0, -Q_ONE));
    endtask

    initial begin : stimulus
        logic [MODE_W-1:0] seg_mode;
        logic [COEF_W-1:0] seg_e;
        logic [COEF_W-1:0] seg_mu;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idling(15, 61);
        directed_events();

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            if (seg == 3) set_idling(61, 15);
            if (seg == 6) set_idling(0, 0);
            case (seg)
                1:       seg_mode = MODE_ESCAPE;
                4:       seg_mode = MODE_STICK;
                6:       seg_mode = MODE_UNUSED;
                default: seg_mode = MODE_REBOUND;
            endcase
            case (seg % 4)
                0: begin seg_e = ONE_Q15;                seg_mu = 16'd0; end
                1: begin seg_e = 16'd0;                  seg_mu = ONE_Q15; end
                2: begin seg_e = 16'hffff;               seg_mu = 16'hffff; end
                default: begin
                    seg_e  = $urandom_range(ONE_Q15);
                    seg_mu = $urandom_range(ONE_Q15);
                end
            endcase
            if (seg == NUM_SEGMENTS - 1) begin
                seg_e  = $urandom();
                seg_mu = $urandom();
            end
            configure(seg_mode, seg_e, seg_mu);
            for (int k = 0; k < SEGMENT_EVENTS; k++) begin
                // hold off once until the block has drained
                if (seg == 0 && k == SEGMENT_EVENTS / 2) begin
                    in_if.valid <= 1'b0;
                    wait_drained();
                end
                send_event(random_event());
            end
        end

        in_if.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/pwi_pkg.sv
rtl/core/pwi_in_if.sv
rtl/core/pwi_out_if.sv
rtl/core/pwi_cfg_if.sv
rtl/core/pwi_lane.sv
rtl/core/pwi_merge.sv
rtl/core/particle_wall_interaction_core.sv
rtl/core/pwi_checker.sv
tb/sv/testbench.sv
